/* src/cbd_pkg.sv */
// Shared constants, types and target codes for the console CPU bus decoder.
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

  // Default work RAM depth in bytes. It must be a power of two.
  localparam int RAM_DEPTH_DEF = 2048;

  // Address map boundaries and special register addresses.
  localparam logic [15:0] ADDR_PPU_BASE   = 16'h2000;
  localparam logic [15:0] ADDR_IO_BASE    = 16'h4000;
  localparam logic [15:0] ADDR_MAPLO_BASE = 16'h4018;
  localparam logic [15:0] ADDR_CART_BASE  = 16'h6000;
  localparam logic [15:0] ADDR_SPR_DMA    = 16'h4014;
  localparam logic [15:0] ADDR_PAD1       = 16'h4016;
  localparam logic [15:0] PPU_ADDR_MASK   = 16'hE007;

  // Length of the CPU stall that a sprite DMA write starts.
  localparam int DMA_STALL_CYCLES = 512;

  // Target codes.
  localparam logic [2:0] TGT_RAM   = 3'd0;
  localparam logic [2:0] TGT_PPU   = 3'd1;
  localparam logic [2:0] TGT_DMA   = 3'd2;
  localparam logic [2:0] TGT_APU   = 3'd3;
  localparam logic [2:0] TGT_PAD   = 3'd4;
  localparam logic [2:0] TGT_MAPLO = 3'd5;
  localparam logic [2:0] TGT_CART  = 3'd6;

  // Access kinds.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PAD1_PRESENT = 1'b0;
  localparam logic CFG_PAD2_PRESENT = 1'b1;

  // Result of decoding one bus access.
  typedef struct packed {
    logic [2:0]  target;
    logic [15:0] target_address;
    logic        ram_access;
    logic        pad_access;
    logic        dma_start;
    logic        read_valid;
    logic [7:0]  local_data;
  } decode_t;

  // Request from the top level to the controller ports.
  typedef struct packed {
    logic valid;
    logic wr;
    logic port2;
    logic strobe_bit;
  } pad_req_t;

endpackage

`default_nettype wire

/* src/console_cpu_bus_decoder.sv */
// Top level of the console CPU bus decoder.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  op, address, write_data, pad buttons
//   out      output     out_valid / out_stall read_data, read_valid, target,
//                                            target_address, dma_start
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// One item is accepted per clock while in_stall is low; each result passes
// through the read stage, which waits for the work RAM read data, and then
// the output register. After reset the RAM is cleared one byte a cycle, and
// in_stall stays high during that sweep. A stalled output holds its item
// while one more item waits in the RAM read stage.
`timescale 1ns / 1ps
`default_nettype none

module console_cpu_bus_decoder #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [15:0] address,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  pad1_buttons,
  input  wire logic [7:0]  pad2_buttons,
  // Output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_data,
  output logic             read_valid,
  output logic [2:0]       target,
  output logic [15:0]      target_address,
  output logic             dma_start,
  // Configuration port
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);
  import cbd_pkg::*;

  localparam int AW = $clog2(RAM_DEPTH);

  logic       pad1_present;
  logic       pad2_present;
  logic       accept;
  logic       clearing;
  logic [7:0] ram_q;
  logic       serial_bit;
  decode_t    dec;
  pad_req_t   pad_req;

  // Read stage registers (waiting for the RAM data).
  logic       s1_valid;
  logic       s1_use_ram;
  logic [7:0] s1_data;
  logic       s1_read_valid;
  logic [2:0] s1_target;
  logic [15:0] s1_target_address;
  logic       s1_dma;
  logic       out_load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pad1_present <= 1'b0;
      pad2_present <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PAD1_PRESENT: pad1_present <= cfg_data;
        CFG_PAD2_PRESENT: pad2_present <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control between the stages.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || (s1_valid && !out_load);
  assign accept   = in_valid && !in_stall;

  cbd_decode u_decode (
    .op      (op),
    .address (address),
    .dec     (dec)
  );

  cbd_ram #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk      (clk),
    .rst      (rst),
    .en       (accept && dec.ram_access),
    .we       (op == OP_WRITE),
    .idx      (address[AW-1:0]),
    .wdata    (write_data),
    .rdata    (ram_q),
    .clearing (clearing)
  );

  // Controller port request for the item being accepted.
  always_comb begin
    pad_req.valid      = accept && dec.pad_access;
    pad_req.wr         = (op == OP_WRITE);
    pad_req.port2      = address[0];
    pad_req.strobe_bit = write_data[0];
  end

  cbd_pads u_pads (
    .clk          (clk),
    .rst          (rst),
    .req          (pad_req),
    .pad1_buttons (pad1_buttons),
    .pad2_buttons (pad2_buttons),
    .pad1_present (pad1_present),
    .pad2_present (pad2_present),
    .serial_bit   (serial_bit)
  );

  // Read stage: capture the decode while the RAM read is in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_use_ram        <= dec.ram_access && dec.read_valid;
      s1_read_valid     <= dec.read_valid;
      s1_target         <= dec.target;
      s1_target_address <= dec.target_address;
      s1_dma            <= dec.dma_start;
      if (dec.pad_access && dec.read_valid) begin
        s1_data <= {7'd0, serial_bit};
      end else begin
        s1_data <= dec.local_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      read_data      <= s1_use_ram ? ram_q : s1_data;
      read_valid     <= s1_read_valid;
      target         <= s1_target;
      target_address <= s1_target_address;
      dma_start      <= s1_dma;
    end
  end

endmodule

`default_nettype wire

/* src/cbd_decode.sv */
// Address decoder: maps one CPU bus access onto its target unit.
`timescale 1ns / 1ps
`default_nettype none

module cbd_decode (
  input  wire logic            op,
  input  wire logic [15:0]     address,
  output cbd_pkg::decode_t     dec
);
  import cbd_pkg::*;

  logic wr;

  assign wr = (op == OP_WRITE);

  // Walk the address map from the bottom up.
  always_comb begin
    dec                = '0;
    dec.target_address = address;
    if (address < ADDR_PPU_BASE) begin
      dec.target     = TGT_RAM;
      dec.ram_access = 1'b1;
      dec.read_valid = !wr;
    end else if (address < ADDR_IO_BASE) begin
      dec.target         = TGT_PPU;
      dec.target_address = address & PPU_ADDR_MASK;
    end else if (address < ADDR_MAPLO_BASE) begin
      if (address == ADDR_SPR_DMA) begin
        dec.target    = TGT_DMA;
        dec.dma_start = wr;
      end else if (address < ADDR_PAD1) begin
        dec.target = TGT_APU;
      end else begin
        dec.target     = TGT_PAD;
        dec.pad_access = 1'b1;
        dec.read_valid = !wr;
      end
    end else if (address < ADDR_CART_BASE) begin
      // Open bus: the high address byte is left on the data lines.
      dec.target     = TGT_MAPLO;
      dec.read_valid = !wr;
      dec.local_data = wr ? 8'h00 : address[15:8];
    end else begin
      dec.target = TGT_CART;
    end
  end

endmodule

`default_nettype wire

/* src/cbd_ram.sv */
// Work RAM: single-port synchronous memory with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module cbd_ram #(
  parameter int RAM_DEPTH = cbd_pkg::RAM_DEPTH_DEF,
  localparam int AW = $clog2(RAM_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          we,
  input  wire logic [AW-1:0] idx,
  input  wire logic [7:0]    wdata,
  output logic [7:0]         rdata,
  output logic               clearing
);

  logic [7:0]    mem [RAM_DEPTH];
  logic [AW-1:0] clr_idx;

  // Clearing sweep: one entry a cycle from reset until the last entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == AW'(RAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Memory port: the sweep owns the write port while it runs.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 8'h00;
    end else if (en && we) begin
      mem[idx] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[idx];
    end
  end

endmodule

`default_nettype wire

/* src/cbd_pads.sv */
// Controller ports: strobe flag and the two serial button shift registers.
`timescale 1ns / 1ps
`default_nettype none

module cbd_pads (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cbd_pkg::pad_req_t req,
  input  wire logic [7:0]        pad1_buttons,
  input  wire logic [7:0]        pad2_buttons,
  input  wire logic              pad1_present,
  input  wire logic              pad2_present,
  output logic                   serial_bit
);
  import cbd_pkg::*;

  logic       strobe_flag;
  logic [7:0] pad1_shift;
  logic [7:0] pad2_shift;

  // Bit shown on a read is taken before the shift.
  assign serial_bit = req.port2 ? pad2_shift[0] : pad1_shift[0];

  // Strobe falls latch the buttons of present ports; reads shift the addressed port.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe_flag <= 1'b0;
      pad1_shift  <= 8'h00;
      pad2_shift  <= 8'h00;
    end else if (req.valid) begin
      if (req.wr) begin
        if (req.strobe_bit) begin
          strobe_flag <= 1'b1;
        end else if (strobe_flag) begin
          strobe_flag <= 1'b0;
          if (pad1_present) begin
            pad1_shift <= pad1_buttons;
          end
          if (pad2_present) begin
            pad2_shift <= pad2_buttons;
          end
        end
      end else if (req.port2) begin
        pad2_shift <= {1'b0, pad2_shift[7:1]};
      end else begin
        pad1_shift <= {1'b0, pad1_shift[7:1]};
      end
    end
  end

endmodule

`default_nettype wire

/* src/cbd_checker.sv */
// Port-level checks for the console CPU bus decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module cbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  read_data,
  input wire logic        read_valid,
  input wire logic [2:0]  target,
  input wire logic [15:0] target_address,
  input wire logic        dma_start
);
  import cbd_pkg::*;

  // A DMA start only comes from the sprite DMA register.
  a_dma_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && dma_start |-> target == TGT_DMA)
    else $error("dma_start on a target other than sprite DMA");

  // Only RAM, controller and open-bus reads are answered here.
  a_local_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |->
      target == TGT_RAM || target == TGT_PAD || target == TGT_MAPLO)
    else $error("read answered locally for a remote target");

  // Forwarded PPU addresses carry the mirror mask.
  a_ppu_mask: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_PPU |-> (target_address & ~PPU_ADDR_MASK) == 16'h0000)
    else $error("PPU address not masked");

  // Open-bus reads return the high address byte, controller reads one bit.
  a_read_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid && target != TGT_RAM |->
      read_data == target_address[15:8] || read_data[7:1] == 7'd0)
    else $error("unexpected local read byte");

  // A stalled result item stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(target))
    else $error("stalled result item changed");

endmodule

bind console_cpu_bus_decoder cbd_checker u_cbd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .read_data      (read_data),
  .read_valid     (read_valid),
  .target         (target),
  .target_address (target_address),
  .dma_start      (dma_start)
);

`default_nettype wire
